// ===== sv/bsm_pkg.sv =====
// Shared types and constants for the bank switch mapper with scanline IRQ.
// Used by the result channel interface, controller, datapath and top level.
package bsm_pkg;

  localparam int unsigned PRG_CNT_W  = 9;
  localparam int unsigned CHR_CNT_W  = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CHR_SLOTS  = 8;
  localparam int unsigned SLOT_W     = $clog2(CHR_SLOTS);
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RST = 9'd16;
  localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RST = 11'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [15:0] ADDR_MASK     = 16'hf00f;
  localparam logic [15:0] ADDR_PRG0     = 16'h8000;
  localparam logic [15:0] ADDR_PRG1     = 16'ha000;
  localparam logic [15:0] ADDR_MIRR     = 16'h9000;
  localparam logic [15:0] ADDR_MODE     = 16'h9002;
  localparam logic [15:0] ADDR_LATCH_LO = 16'hf000;
  localparam logic [15:0] ADDR_LATCH_HI = 16'hf002;
  localparam logic [15:0] ADDR_IRQ_ACK  = 16'hf003;
  localparam logic [15:0] ADDR_IRQ_CTRL = 16'hf004;

  localparam logic [3:0] CHR_PAGE_FIRST = 4'hb;
  localparam logic [3:0] CHR_PAGE_LAST  = 4'he;

  // low address nibble inside a character register page
  localparam logic [3:0] CHR_EVEN_LO  = 4'h0;
  localparam logic [3:0] CHR_EVEN_HI  = 4'h2;
  localparam logic [3:0] CHR_ODD_LO_A = 4'h1;
  localparam logic [3:0] CHR_ODD_LO_B = 4'h4;
  localparam logic [3:0] CHR_ODD_HI_A = 4'h3;
  localparam logic [3:0] CHR_ODD_HI_B = 4'h6;

  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_PRG  = 2'd1,
    UPD_CHR  = 2'd2,
    UPD_MIRR = 2'd3
  } upd_kind_e;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic div_step;
    logic load_div;
  } bsm_cmd_t;

  typedef struct packed {
    logic need_div;
  } bsm_stat_t;

endpackage

// ===== sv/bsm_in_if.sv =====
// Input channel: CPU write or scanline tick, valid/ready handshake.
// Depends on nothing.
interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] addr;
  logic [7:0]  wdata;

  modport source (output valid, func, addr, wdata, input ready);
  modport sink   (input valid, func, addr, wdata, output ready);
endinterface

// ===== sv/bsm_out_if.sv =====
// Result channel: bank update or IRQ request, valid/ready handshake.
// Depends on bsm_pkg for the update kind type.
interface bsm_out_if;
  logic                        valid;
  logic                        ready;
  bsm_pkg::upd_kind_e          update_kind;
  logic [bsm_pkg::SLOT_W-1:0]  slot;
  logic [7:0]                  bank;
  logic                        irq_request;

  modport source (output valid, update_kind, slot, bank, irq_request, input ready);
  modport sink   (input valid, update_kind, slot, bank, irq_request, output ready);
endinterface

// ===== sv/bsm_ctrl.sv =====
// Controller: handshakes, bit-serial modulo sequencing, result register valid.
// Depends on bsm_pkg for command and status structs.
module bsm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bsm_pkg::bsm_stat_t stat_i,
  output bsm_pkg::bsm_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [bsm_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;
  logic                            accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept      = accept;
    cmd_o.load_direct = accept && !stat_i.need_div;
    cmd_o.div_step    = (state_q == ST_DIV);
    cmd_o.load_div    = (state_q == ST_DONE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.need_div) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == bsm_pkg::DIV_CNT_W'(bsm_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the remainder until the result register frees up
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_direct || cmd_o.load_div) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/bsm_datapath.sv =====
// Datapath: address decode, mapper registers, IRQ counter, bit-serial modulo
// and the result register. Depends on bsm_pkg.
module bsm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              func_i,
  input  logic [15:0]                       addr_i,
  input  logic [7:0]                        wdata_i,
  input  bsm_pkg::bsm_cmd_t                 cmd_i,
  output bsm_pkg::bsm_stat_t                stat_o,
  output bsm_pkg::upd_kind_e                update_kind_o,
  output logic [bsm_pkg::SLOT_W-1:0]        slot_o,
  output logic [7:0]                        bank_o,
  output logic                              irq_request_o
);

  logic [bsm_pkg::PRG_CNT_W-1:0] prg_cnt_q;
  logic [bsm_pkg::CHR_CNT_W-1:0] chr_cnt_q;
  logic [7:0]                    chr_regs_q [bsm_pkg::CHR_SLOTS];
  logic [7:0]                    mode_q;
  logic [1:0]                    irq_en_q;
  logic [7:0]                    irq_cnt_q;
  logic [7:0]                    irq_latch_q;

  // decode
  logic [15:0]                   a;
  logic [3:0]                    h, l;
  logic [3:0]                    chr_page;
  logic                          chr_page_hit, chr_hit, chr_hi, chr_odd;
  logic [bsm_pkg::SLOT_W-1:0]    chr_slot;
  logic [7:0]                    chr_old, chr_new;
  logic                          is_write;
  logic                          wr_mode, wr_latch_lo, wr_latch_hi, wr_ack, wr_ctrl;
  logic                          tick_on, tick_wrap;

  bsm_pkg::upd_kind_e            dec_kind;
  logic [bsm_pkg::SLOT_W-1:0]    dec_slot;
  logic [7:0]                    dec_val;
  logic [bsm_pkg::CHR_CNT_W-1:0] dec_den;

  // modulo unit
  logic [bsm_pkg::SLOT_W-1:0]    pend_slot_q;
  bsm_pkg::upd_kind_e            pend_kind_q;
  logic [7:0]                    num_q, rem_q;
  logic [bsm_pkg::CHR_CNT_W-1:0] den_q;
  logic [8:0]                    rem_sh, rem_sub;
  logic                          rem_ge;

  // result register
  bsm_pkg::upd_kind_e            out_kind_q;
  logic [bsm_pkg::SLOT_W-1:0]    out_slot_q;
  logic [7:0]                    out_bank_q;
  logic                          out_irq_q;

  assign a        = addr_i & bsm_pkg::ADDR_MASK;
  assign h        = a[15:12];
  assign l        = a[3:0];
  assign is_write = (func_i == bsm_pkg::FUNC_WRITE);
  assign chr_page = h - bsm_pkg::CHR_PAGE_FIRST;
  assign chr_page_hit = (h >= bsm_pkg::CHR_PAGE_FIRST) && (h <= bsm_pkg::CHR_PAGE_LAST);

  always_comb begin
    chr_hit = 1'b1;
    chr_hi  = 1'b0;
    chr_odd = 1'b0;
    case (l)
      bsm_pkg::CHR_EVEN_LO: ;
      bsm_pkg::CHR_EVEN_HI: chr_hi = 1'b1;
      bsm_pkg::CHR_ODD_LO_A, bsm_pkg::CHR_ODD_LO_B: chr_odd = 1'b1;
      bsm_pkg::CHR_ODD_HI_A, bsm_pkg::CHR_ODD_HI_B: begin
        chr_odd = 1'b1;
        chr_hi  = 1'b1;
      end
      default: chr_hit = 1'b0;
    endcase
    chr_hit = chr_hit && chr_page_hit && is_write;
  end

  assign chr_slot = {chr_page[1:0], chr_odd};
  assign chr_old  = chr_regs_q[chr_slot];
  assign chr_new  = chr_hi ? {wdata_i[3:0], chr_old[3:0]} : {chr_old[7:4], wdata_i[3:0]};

  assign wr_mode     = is_write && (a == bsm_pkg::ADDR_MODE);
  assign wr_latch_lo = is_write && (a == bsm_pkg::ADDR_LATCH_LO);
  assign wr_latch_hi = is_write && (a == bsm_pkg::ADDR_LATCH_HI);
  assign wr_ack      = is_write && (a == bsm_pkg::ADDR_IRQ_ACK);
  assign wr_ctrl     = is_write && (a == bsm_pkg::ADDR_IRQ_CTRL);
  assign tick_on     = !is_write && irq_en_q[1];
  assign tick_wrap   = tick_on && (irq_cnt_q == 8'hff);

  always_comb begin
    dec_kind = bsm_pkg::UPD_NONE;
    dec_slot = '0;
    dec_val  = '0;
    dec_den  = '0;
    if (is_write) begin
      if (a == bsm_pkg::ADDR_PRG0) begin
        dec_kind = bsm_pkg::UPD_PRG;
        dec_slot = mode_q[1] ? bsm_pkg::SLOT_W'(2) : '0;
        dec_val  = wdata_i;
        dec_den  = bsm_pkg::CHR_CNT_W'(prg_cnt_q);
      end else if (a == bsm_pkg::ADDR_PRG1) begin
        dec_kind = bsm_pkg::UPD_PRG;
        dec_slot = bsm_pkg::SLOT_W'(1);
        dec_val  = wdata_i;
        dec_den  = bsm_pkg::CHR_CNT_W'(prg_cnt_q);
      end else if (a == bsm_pkg::ADDR_MIRR) begin
        dec_kind = bsm_pkg::UPD_MIRR;
        dec_val  = {6'd0, wdata_i[1:0]};
      end else if (chr_hit) begin
        dec_kind = bsm_pkg::UPD_CHR;
        dec_slot = chr_slot;
        dec_val  = chr_new;
        dec_den  = chr_cnt_q;
      end
    end
  end

  // zero count passes the value unreduced, so only nonzero counts divide
  assign stat_o.need_div = (dec_kind == bsm_pkg::UPD_PRG || dec_kind == bsm_pkg::UPD_CHR)
                           && (dec_den != '0);

  // one restoring step per cycle, MSB of the dividend first
  assign rem_sh  = {rem_q, num_q[7]};
  assign rem_ge  = {2'b00, rem_sh} >= den_q;
  assign rem_sub = rem_sh - den_q[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q   <= bsm_pkg::PRG_COUNT_RST;
      chr_cnt_q   <= bsm_pkg::CHR_COUNT_RST;
      mode_q      <= '0;
      irq_en_q    <= '0;
      irq_cnt_q   <= '0;
      irq_latch_q <= '0;
      for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
        chr_regs_q[i] <= 8'(i);
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bsm_pkg::CFG_PRG_COUNT: prg_cnt_q <= cfg_wdata_i[bsm_pkg::PRG_CNT_W-1:0];
          bsm_pkg::CFG_CHR_COUNT: chr_cnt_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (chr_hit) begin
          chr_regs_q[chr_slot] <= chr_new;
        end
        if (wr_mode) begin
          mode_q <= wdata_i;
        end
        if (wr_latch_lo) begin
          irq_latch_q[3:0] <= wdata_i[3:0];
        end
        if (wr_latch_hi) begin
          irq_latch_q[7:4] <= wdata_i[3:0];
        end
        if (wr_ack || tick_wrap) begin
          irq_en_q[1] <= irq_en_q[0];
        end
        if (wr_ctrl) begin
          irq_en_q <= wdata_i[1:0];
        end
        if ((wr_ctrl && wdata_i[1]) || tick_wrap) begin
          irq_cnt_q <= irq_latch_q;
        end else if (tick_on) begin
          irq_cnt_q <= irq_cnt_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_kind_q <= dec_kind;
      pend_slot_q <= dec_slot;
      num_q       <= dec_val;
      den_q       <= dec_den;
      rem_q       <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[6:0], 1'b0};
      rem_q <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
    end
    if (cmd_i.load_direct) begin
      out_kind_q <= dec_kind;
      out_slot_q <= dec_slot;
      out_bank_q <= dec_val;
      out_irq_q  <= tick_wrap;
    end else if (cmd_i.load_div) begin
      out_kind_q <= pend_kind_q;
      out_slot_q <= pend_slot_q;
      out_bank_q <= rem_q;
      out_irq_q  <= 1'b0;
    end
  end

  assign update_kind_o = out_kind_q;
  assign slot_o        = out_slot_q;
  assign bank_o        = out_bank_q;
  assign irq_request_o = out_irq_q;

endmodule

// ===== sv/bank_switch_mapper_scanline_irq.sv =====
// Top level of the bank switch mapper with scanline IRQ counter.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if, bsm_ctrl and bsm_datapath.
//
//   channel  | dir | payload                                  | handshake
//   in_i     | in  | func, addr[15:0], wdata[7:0]              | valid/ready
//   out_o    | out | update_kind[1:0], slot[2:0], bank[7:0],   | valid/ready
//            |     | irq_request                               |
//   cfg      | in  | cfg_idx_i, cfg_wdata_i[10:0]              | cfg_we_i
//
// Ticks, mirroring, mode, IRQ and unmapped writes and zero bank counts are
// taken at one item per cycle while results drain. A bank write with a
// nonzero count: accept, 8 bit-serial modulo steps and one result load.
// One item is in flight at a time; a waiting result blocks the input, which
// opens again in the cycle the result register drains. A stalled result holds
// the modulo unit in its final state. Reset is asynchronous, active low, and
// restores all mapper registers at once.
module bank_switch_mapper_scanline_irq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bsm_in_if.sink                          in_i,
  bsm_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  bsm_pkg::bsm_cmd_t  cmd;
  bsm_pkg::bsm_stat_t stat;

  bsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bsm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (in_i.func),
    .addr_i        (in_i.addr),
    .wdata_i       (in_i.wdata),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .update_kind_o (out_o.update_kind),
    .slot_o        (out_o.slot),
    .bank_o        (out_o.bank),
    .irq_request_o (out_o.irq_request)
  );

endmodule

// ===== sim/bsm_update_checker.sv =====
// Checker for the bank switch mapper: watches the input, result and count write ports,
// predicts every result beat and compares it field by field.
// Depends on bsm_pkg, bsm_in_if and bsm_out_if.
`timescale 1ns / 1ps

module bsm_update_checker
  import bsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bsm_in_if                    in_mon,
  bsm_out_if                   out_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   results_o,
  output int                   irqs_o
);

  typedef struct packed {
    upd_kind_e   kind;
    logic [2:0]  slot;
    logic [7:0]  bank;
    logic        irq;
  } mapper_update_t;

  // mirrored mapper state
  logic [7:0]           chr_regs [CHR_SLOTS];
  logic [7:0]           mode_q;
  logic [1:0]           irq_en_q;
  logic [7:0]           irq_cnt_q;
  logic [7:0]           irq_latch_q;
  logic [PRG_CNT_W-1:0] prg_count_q;
  logic [CHR_CNT_W-1:0] chr_count_q;

  mapper_update_t awaited_updates [$];

  // a zero count passes the bank number through unreduced
  function automatic logic [10:0] reduce_bank(input logic [10:0] value,
                                              input logic [10:0] modulus);
    return (modulus == 11'd0) ? value : value % modulus;
  endfunction

  function automatic mapper_update_t next_mapper_update(input logic func,
                                                        input logic [15:0] addr,
                                                        input logic [7:0] wdata);
    mapper_update_t upd;
    logic [15:0]    a;
    logic [3:0]     page;
    logic [3:0]     sub;
    logic [2:0]     s;
    logic           hit;
    logic           hi;
    logic [7:0]     r;
    upd  = '0;
    a    = addr & ADDR_MASK;
    page = a[15:12];
    sub  = a[3:0];
    if (func == FUNC_TICK) begin
      if (irq_en_q[1]) begin
        if (irq_cnt_q == 8'hff) begin
          irq_cnt_q   = irq_latch_q;
          irq_en_q[1] = irq_en_q[0];
          upd.irq     = 1'b1;
        end else begin
          irq_cnt_q = irq_cnt_q + 8'd1;
        end
      end
    end else if (a == ADDR_PRG0) begin
      upd.kind = UPD_PRG;
      upd.slot = mode_q[1] ? 3'd2 : 3'd0;
      upd.bank = 8'(reduce_bank(11'(wdata), 11'(prg_count_q)));
    end else if (a == ADDR_PRG1) begin
      upd.kind = UPD_PRG;
      upd.slot = 3'd1;
      upd.bank = 8'(reduce_bank(11'(wdata), 11'(prg_count_q)));
    end else if (a == ADDR_MIRR) begin
      upd.kind = UPD_MIRR;
      upd.bank = {6'd0, wdata[1:0]};
    end else if (a == ADDR_MODE) begin
      mode_q = wdata;
    end else if (page >= CHR_PAGE_FIRST && page <= CHR_PAGE_LAST) begin
      s   = 3'((page - CHR_PAGE_FIRST) << 1);
      hit = 1'b1;
      hi  = 1'b0;
      case (sub)
        CHR_EVEN_LO: ;
        CHR_EVEN_HI: hi = 1'b1;
        CHR_ODD_LO_A, CHR_ODD_LO_B: s = s + 3'd1;
        CHR_ODD_HI_A, CHR_ODD_HI_B: begin
          s  = s + 3'd1;
          hi = 1'b1;
        end
        default: hit = 1'b0;
      endcase
      if (hit) begin
        r = chr_regs[s];
        if (hi) r[7:4] = wdata[3:0];
        else    r[3:0] = wdata[3:0];
        chr_regs[s] = r;
        upd.kind = UPD_CHR;
        upd.slot = s;
        upd.bank = 8'(reduce_bank(11'(r), chr_count_q));
      end
    end else if (a == ADDR_LATCH_LO) begin
      irq_latch_q[3:0] = wdata[3:0];
    end else if (a == ADDR_LATCH_HI) begin
      irq_latch_q[7:4] = wdata[3:0];
    end else if (a == ADDR_IRQ_ACK) begin
      irq_en_q[1] = irq_en_q[0];
    end else if (a == ADDR_IRQ_CTRL) begin
      irq_en_q = wdata[1:0];
      if (irq_en_q[1]) irq_cnt_q = irq_latch_q;
    end
    return upd;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t ns: result %0d %s mismatch, expected %0d, actual %0d",
               $time, results_o, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mapper_update_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CHR_SLOTS; i++) chr_regs[i] = 8'(i);
      mode_q      = '0;
      irq_en_q    = '0;
      irq_cnt_q   = '0;
      irq_latch_q = '0;
      prg_count_q = PRG_COUNT_RST;
      chr_count_q = CHR_COUNT_RST;
      awaited_updates.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PRG_COUNT) prg_count_q = cfg_wdata_i[PRG_CNT_W-1:0];
        else                            chr_count_q = cfg_wdata_i[CHR_CNT_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_updates.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: unexpected result beat, expected none, actual %0d/%0d/%0d/%0d",
                   $time, out_mon.update_kind, out_mon.slot, out_mon.bank,
                   out_mon.irq_request);
        end else begin
          want = awaited_updates.pop_front();
          check_field("update_kind", 8'(want.kind), 8'(out_mon.update_kind));
          check_field("slot", 8'(want.slot), 8'(out_mon.slot));
          check_field("bank", want.bank, out_mon.bank);
          check_field("irq_request", 8'(want.irq), 8'(out_mon.irq_request));
          if (want.irq) irqs_o++;
        end
        results_o++;
      end
      if (in_mon.valid && in_mon.ready)
        awaited_updates.push_back(next_mapper_update(in_mon.func, in_mon.addr,
                                                     in_mon.wdata));
    end
    pending_o = awaited_updates.size();
  end

endmodule

// ===== sim/tb_bank_switch_mapper_scanline_irq.sv =====
// Testbench top for the bank switch mapper: drives CPU writes, scanline ticks and
// bank count settings, with random stalls on both channels; bsm_update_checker judges.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if, bsm_update_checker and the mapper RTL.
`timescale 1ns / 1ps

module tb_bank_switch_mapper_scanline_irq;
  import bsm_pkg::*;

  localparam logic [3:0] CHR_SUBS [6] = '{CHR_EVEN_LO, CHR_EVEN_HI, CHR_ODD_LO_A,
                                          CHR_ODD_LO_B, CHR_ODD_HI_A, CHR_ODD_HI_B};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  no_idle;
  int                    fail_count;
  int                    pending;
  int                    results;
  int                    irqs;
  int                    beats_sent;
  int                    ticks_sent;
  int                    settings_used;

  bsm_in_if  in_ch ();
  bsm_out_if out_ch ();

  bank_switch_mapper_scanline_irq DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  bsm_update_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .irqs_o      (irqs)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stalls about 6 beats in 100 unless the quiet stretch is on
  always @(posedge clk_i) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 6);
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic put_beat(input logic func, input logic [15:0] addr,
                          input logic [7:0] wdata);
    while (!no_idle && $urandom_range(0, 99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.addr  <= addr;
    in_ch.wdata <= wdata;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beats_sent++;
    if (func == FUNC_TICK) ticks_sent++;
  endtask

  task automatic cpu_write(input logic [15:0] addr, input logic [7:0] wdata);
    put_beat(FUNC_WRITE, addr, wdata);
  endtask

  // address and data are don't-care on a tick; keep them moving anyway
  task automatic scanline();
    put_beat(FUNC_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [10:0] prg, input logic [10:0] chr);
    logic prg_first;
    wait_for_results();
    prg_first = 1'($urandom);
    cfg_we    <= 1'b1;
    cfg_idx   <= prg_first ? CFG_PRG_COUNT : CFG_CHR_COUNT;
    cfg_wdata <= prg_first ? prg : chr;
    @(posedge clk_i);
    cfg_idx   <= prg_first ? CFG_CHR_COUNT : CFG_PRG_COUNT;
    cfg_wdata <= prg_first ? chr : prg;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic directed_beats();
    scanline();                    // counting still disabled
    cpu_write(ADDR_PRG0, 8'hff);
    cpu_write(ADDR_PRG1, 8'h00);
    cpu_write(ADDR_MODE, 8'h02);
    cpu_write(16'h8ff0, 8'h80);    // middle address bits are masked off
    cpu_write(ADDR_MODE, 8'hfd);
    cpu_write(ADDR_MIRR, 8'hff);
    cpu_write(16'hb000, 8'h0f);
    cpu_write(16'hb002, 8'hff);
    cpu_write(16'hc001, 8'h0a);
    cpu_write(16'hd004, 8'h05);
    cpu_write(16'he003, 8'hff);
    cpu_write(16'hb005, 8'hff);    // unused nibble in a character page
    cpu_write(16'h0000, 8'h00);
    cpu_write(16'hffff, 8'hff);
    cpu_write(ADDR_LATCH_LO, 8'h0e);
    cpu_write(ADDR_LATCH_HI, 8'hff);
    cpu_write(ADDR_IRQ_CTRL, 8'h03);
    repeat (2) scanline();         // overflow, stays armed
    cpu_write(ADDR_IRQ_CTRL, 8'h02);
    repeat (3) scanline();         // overflow disarms, then nothing
    cpu_write(ADDR_IRQ_CTRL, 8'h01);
    cpu_write(ADDR_IRQ_ACK, 8'h00);
    scanline();
  endtask

  task automatic random_traffic(input int beats);
    int          done;
    int          pick;
    int          run;
    logic [15:0] mid;
    logic [3:0]  sub;
    done = 0;
    while (done < beats) begin
      pick = $urandom_range(0, 99);
      mid  = {4'h0, 8'($urandom), 4'h0};
      run  = 1;
      if (pick < 12) begin
        cpu_write(($urandom_range(0, 1) ? ADDR_PRG0 : ADDR_PRG1) | mid, 8'($urandom));
      end else if (pick < 17) begin
        cpu_write(ADDR_MIRR | mid, 8'($urandom));
      end else if (pick < 22) begin
        cpu_write(ADDR_MODE | mid, 8'($urandom));
      end else if (pick < 47) begin
        sub = ($urandom_range(0, 9) == 0) ? 4'($urandom) : CHR_SUBS[$urandom_range(0, 5)];
        cpu_write({4'($urandom_range(CHR_PAGE_FIRST, CHR_PAGE_LAST)), mid[11:4], sub},
                  8'($urandom));
      end else if (pick < 52) begin
        // arm the counter near the top so overflows come often
        cpu_write(ADDR_LATCH_HI | mid,
                  {4'($urandom), ($urandom_range(0, 9) < 7) ? 4'hf : 4'($urandom)});
        cpu_write(ADDR_LATCH_LO | mid, 8'($urandom));
        cpu_write(ADDR_IRQ_CTRL | mid, {6'($urandom), 1'($urandom_range(0, 9) < 8),
                                        1'($urandom)});
        run = $urandom_range(4, 20);
        repeat (run) scanline();
        run = run + 3;
      end else if (pick < 57) begin
        cpu_write((($urandom_range(0, 1) ? ADDR_LATCH_LO : ADDR_LATCH_HI)) | mid,
                  8'($urandom));
      end else if (pick < 61) begin
        cpu_write(ADDR_IRQ_CTRL | mid, 8'($urandom));
      end else if (pick < 65) begin
        cpu_write(ADDR_IRQ_ACK | mid, 8'($urandom));
      end else if (pick < 90) begin
        run = $urandom_range(1, 12);
        repeat (run) scanline();
      end else begin
        put_beat(1'($urandom), 16'($urandom), 8'($urandom));
      end
      done += run;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_WRITE;
    in_ch.addr    = '0;
    in_ch.wdata   = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_PRG_COUNT;
    cfg_wdata     = '0;
    no_idle       = 1'b0;
    beats_sent    = 0;
    ticks_sent    = 0;
    settings_used = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_beats();
    random_traffic(115);
    for (int phase = 1; phase < 7; phase++) begin
      case (phase)
        1: set_counts(11'd0, 11'd0);
        2: set_counts(11'd510, 11'd2040);
        3: set_counts(11'd1, 11'd1);
        4: set_counts(11'($urandom), 11'($urandom));
        5: set_counts(11'h7ff, 11'h7ff);
        default: set_counts(11'($urandom_range(1, 40)), 11'($urandom_range(1, 300)));
      endcase
      no_idle = (phase == 2);
      random_traffic(115);
    end
    no_idle = 1'b0;

    wait_for_results();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d beats (%0d scanline ticks) under %0d bank count settings.",
             beats_sent, ticks_sent, settings_used);
    $display("Checked %0d result beats, %0d of them IRQ requests.", results, irqs);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
